FILE: hdl/foia_pkg.sv
// Package for the four-operation integer ALU: data width, operation codes and
// the structures passed between the top level and the serial engine.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package foia_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int REQ_TYPE_W = 2;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef enum logic [REQ_TYPE_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op_code;

    // Operation handed to the engine when a transaction is accepted.
    typedef struct packed {
        logic [REQ_TYPE_W-1:0] req_type;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
    } t_eng_req;

    // Finished result offered by the engine.
    typedef struct packed {
        logic [DATA_WIDTH-1:0] result_value;
        logic                  divide_by_zero;
    } t_eng_res;

    typedef struct packed {
        logic start;
        logic res_ready;
    } t_eng_ctl;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } t_eng_stat;

endpackage

FILE: hdl/foia_req_if.sv
// Request channel of the four-operation integer ALU: valid, ready and payload.
// Depends on foia_pkg.
`timescale 1ns / 1ps

interface foia_req_if import foia_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic        [REQ_TYPE_W-1:0] req_type;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;

    modport source (output valid, output req_type, output operand_a, output operand_b,
                    input ready);
    modport sink   (input valid, input req_type, input operand_a, input operand_b,
                    output ready);
endinterface

FILE: hdl/foia_rsp_if.sv
// Response channel of the four-operation integer ALU: valid, ready and payload.
// Depends on foia_pkg.
`timescale 1ns / 1ps

interface foia_rsp_if import foia_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic                         divide_by_zero;

    modport source (output valid, output result_value, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input result_value, input divide_by_zero,
                    output ready);
endinterface

FILE: hdl/four_op_integer_alu.sv
// Top level of the four-operation integer ALU: request/response handshakes,
// output register and the serial engine. Depends on foia_pkg, foia_req_if,
// foia_rsp_if and foia_engine.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Payload
//  ---------+-----------+-------------------------------------------------
//  i_req    | in        | req_type, operand_a, operand_b
//  o_rsp    | out       | result_value, divide_by_zero
//
//  Add, subtract and a divide by zero are worked out at load and then offered;
//  multiply and divide go through a load step, bit-serial iterations of the
//  shared adder and a sign-fix step, one operand bit handled per cycle.
//  The result then sits in an output register, so a new transaction is taken
//  while the previous result waits to be accepted downstream.
//  Reset is synchronous and active low; it clears the engine state and the
//  output valid flag. A stalled output holds the engine in its final state.

module four_op_integer_alu import foia_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    foia_req_if.sink    i_req,
    foia_rsp_if.source  o_rsp
);

    t_eng_ctl  eng_ctl;
    t_eng_req  eng_req;
    t_eng_stat eng_stat;
    t_eng_res  eng_res;

    logic                  r_valid, n_valid;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic                  r_dz, n_dz;
    logic                  slot_free;

    // The engine takes a new transaction whenever it has nothing in flight.
    assign i_req.ready = eng_stat.idle;

    assign eng_ctl.start     = i_req.valid && eng_stat.idle;
    assign eng_req.req_type  = i_req.req_type;
    assign eng_req.operand_a = i_req.operand_a;
    assign eng_req.operand_b = i_req.operand_b;

    // The output register can take a result when it is empty or being drained.
    assign slot_free         = !r_valid || o_rsp.ready;
    assign eng_ctl.res_ready = slot_free;

    foia_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_req   (eng_req),
        .o_stat  (eng_stat),
        .o_res   (eng_res)
    );

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_dz    = r_dz;
        if (slot_free) begin
            n_valid = eng_stat.res_valid;
            if (eng_stat.res_valid) begin
                n_value = eng_res.result_value;
                n_dz    = eng_res.divide_by_zero;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_dz    <= n_dz;
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.result_value   = r_value;
    assign o_rsp.divide_by_zero = r_dz;

endmodule

FILE: hdl/foia_engine.sv
// Serial arithmetic engine: shift-and-add multiply and restoring divide, one
// operand bit per cycle through shift registers, plus add/subtract computed at load.
// Depends on foia_pkg.
`timescale 1ns / 1ps

module foia_engine import foia_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_eng_ctl  i_ctl,
    input  t_eng_req  i_req,
    output t_eng_stat o_stat,
    output t_eng_res  o_res
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIX  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_div, n_div;
    logic                  r_neg, n_neg;
    logic                  r_dz, n_dz;

    logic [DATA_WIDTH-1:0] rem_sh;
    logic [DATA_WIDTH-1:0] add_a;
    logic [DATA_WIDTH-1:0] add_b;
    logic [DATA_WIDTH:0]   sum;
    logic                  take;
    logic [DATA_WIDTH-1:0] res_sel;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;

    // One shared adder: accumulate for multiply, trial subtract for divide.
    always_comb begin
        rem_sh = {r_acc[DATA_WIDTH-2:0], r_y[DATA_WIDTH-1]};
        add_a  = r_div ? rem_sh : r_acc;
        add_b  = r_div ? ~r_x : r_x;
        sum    = {1'b0, add_a} + {1'b0, add_b} + (DATA_WIDTH + 1)'(r_div);
        // The dropped remainder bit or a carry out means the divisor fits.
        take   = r_acc[DATA_WIDTH-1] | sum[DATA_WIDTH];
    end

    assign mag_a = i_req.operand_a[DATA_WIDTH-1] ? (~i_req.operand_a + 1'b1) : i_req.operand_a;
    assign mag_b = i_req.operand_b[DATA_WIDTH-1] ? (~i_req.operand_b + 1'b1) : i_req.operand_b;

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_x     = r_x;
        n_y     = r_y;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_neg   = r_neg;
        n_dz    = r_dz;
        case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_div = 1'b0;
                    n_neg = 1'b0;
                    n_dz  = 1'b0;
                    n_acc = '0;
                    n_x   = i_req.operand_a;
                    n_y   = i_req.operand_b;
                    n_cnt = CNT_W'(DATA_WIDTH - 1);
                    case (t_op_code'(i_req.req_type))
                        OP_ADD: begin
                            n_acc   = i_req.operand_a + i_req.operand_b;
                            n_state = ST_FIX;
                        end
                        OP_SUB: begin
                            n_acc   = i_req.operand_a - i_req.operand_b;
                            n_state = ST_FIX;
                        end
                        OP_MUL: begin
                            n_state = ST_RUN;
                        end
                        OP_DIV: begin
                            if (i_req.operand_b == '0) begin
                                n_dz    = 1'b1;
                                n_state = ST_FIX;
                            end else begin
                                n_div   = 1'b1;
                                n_neg   = i_req.operand_a[DATA_WIDTH-1]
                                          ^ i_req.operand_b[DATA_WIDTH-1];
                                n_x     = mag_b;
                                n_y     = mag_a;
                                n_state = ST_RUN;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (r_div) begin
                    n_acc = take ? sum[DATA_WIDTH-1:0] : rem_sh;
                    n_y   = {r_y[DATA_WIDTH-2:0], take};
                end else begin
                    n_acc = r_y[0] ? sum[DATA_WIDTH-1:0] : r_acc;
                    n_x   = {r_x[DATA_WIDTH-2:0], 1'b0};
                    n_y   = {1'b0, r_y[DATA_WIDTH-1:1]};
                end
                if (r_cnt == '0) begin
                    n_state = ST_FIX;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_FIX: begin
                if (i_ctl.res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
        r_cnt <= n_cnt;
        r_div <= n_div;
        r_neg <= n_neg;
        r_dz  <= n_dz;
    end

    // The quotient ends up in the dividend register, everything else in the accumulator.
    assign res_sel             = r_div ? r_y : r_acc;
    assign o_res.result_value  = r_neg ? (~res_sel + 1'b1) : res_sel;
    assign o_res.divide_by_zero = r_dz;
    assign o_stat.idle         = (r_state == ST_IDLE);
    assign o_stat.res_valid    = (r_state == ST_FIX);

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == ST_IDLE)
        else $error("engine started while busy");
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX && r_dz) |-> o_res.result_value == '0)
        else $error("zero divisor gave a nonzero result");
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_cnt == '0) |=> r_state == ST_FIX)
        else $error("serial run did not finish after the last bit");
    a_fix_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX && !i_ctl.res_ready) |=>
            (r_state == ST_FIX && $stable(o_res.result_value)))
        else $error("pending result changed before it was taken");
`endif

endmodule

FILE: dv/tb_four_op_integer_alu.sv
// Self-checking testbench for the four-operation integer ALU: directed corner cases, then
// random add, subtract, multiply and divide transactions under random back-pressure.
// Depends on foia_pkg, foia_req_if, foia_rsp_if and four_op_integer_alu.
`timescale 1ns / 1ps

// Holds the expected outcome of every accepted request, in order, and compares each
// returned response with the oldest one.
class alu_result_scoreboard;

    typedef struct {
        logic [foia_pkg::DATA_WIDTH-1:0] value;
        logic                            div_zero;
    } t_alu_outcome;

    t_alu_outcome pending_outcomes[$];
    int unsigned  fail_count;

    function new();
        fail_count = 0;
    endfunction

    // Works out the result of an accepted request and queues it.
    function void note_request(foia_pkg::t_op_code op,
                               logic [foia_pkg::DATA_WIDTH-1:0] a,
                               logic [foia_pkg::DATA_WIDTH-1:0] b);
        t_alu_outcome                    outcome;
        logic [foia_pkg::DATA_WIDTH-1:0] mag_a;
        logic [foia_pkg::DATA_WIDTH-1:0] mag_b;
        logic [foia_pkg::DATA_WIDTH-1:0] quotient;
        outcome.div_zero = 1'b0;
        case (op)
            foia_pkg::OP_ADD: outcome.value = a + b;
            foia_pkg::OP_SUB: outcome.value = a - b;
            foia_pkg::OP_MUL: outcome.value = a * b;
            default: begin
                if (b == '0) begin
                    outcome.value    = '0;
                    outcome.div_zero = 1'b1;
                end else begin
                    mag_a    = a[foia_pkg::DATA_WIDTH-1] ? -a : a;
                    mag_b    = b[foia_pkg::DATA_WIDTH-1] ? -b : b;
                    quotient = mag_a / mag_b;
                    outcome.value = (a[foia_pkg::DATA_WIDTH-1] ^ b[foia_pkg::DATA_WIDTH-1]) ?
                                    -quotient : quotient;
                end
            end
        endcase
        pending_outcomes.push_back(outcome);
    endfunction

    task report(string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        fail_count++;
    endtask

    task check_result(logic [foia_pkg::DATA_WIDTH-1:0] value, logic div_zero);
        t_alu_outcome wanted;
        if (pending_outcomes.size() == 0) begin
            report($sformatf("response %h/%b with no request outstanding", value, div_zero));
        end else begin
            wanted = pending_outcomes.pop_front();
            if (value !== wanted.value)
                report($sformatf("result_value %h, expected %h", value, wanted.value));
            if (div_zero !== wanted.div_zero)
                report($sformatf("divide_by_zero %b, expected %b", div_zero, wanted.div_zero));
        end
    endtask

endclass

module tb_four_op_integer_alu;
    import foia_pkg::*;

    // Cycles without any transaction on either channel before the run is abandoned. The
    // longest legitimate quiet stretch is the deliberate receiver hold-off plus one
    // multi-cycle operation and both idle gaps, well below this figure.
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    // Results after which the receiver starts its long hold-off.
    localparam int HOLD_OFF_AT     = 30;
    localparam int RANDOM_ITEMS    = 1000;
    // Quiet cycles allowed at the end, longer than any engine operation.
    localparam int DRAIN_CYCLES    = 60;

    localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINUS_1  = '1;

    logic i_clk;
    logic i_rst_n;

    foia_req_if req_if ();
    foia_rsp_if rsp_if ();

    four_op_integer_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    alu_result_scoreboard alu_sb = new();

    int unsigned item_index;
    int unsigned results_seen;
    int unsigned quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Both monitors sample at the rising edge, before any flop in the block has updated.
    // A request is noted in the scoreboard as soon as it is accepted, so its expectation is
    // always queued ahead of the response it causes.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            alu_sb.note_request(t_op_code'(req_if.req_type), req_if.operand_a,
                                req_if.operand_b);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            alu_sb.check_result(rsp_if.result_value, rsp_if.divide_by_zero);
            results_seen <= results_seen + 1;
        end
    end

    // The watchdog counts consecutive cycles in which neither channel completes a
    // transaction and ends the run with a failure if that stretch grows too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
        $display("[%0t] watchdog expired after %0d quiet cycles", $realtime, quiet_cycles);
        $display("Test completed with failures");
        $finish;
    end

    // Offers one request after an idle gap of the given number of cycles. All changes are
    // made at the falling edge; with no gap, valid simply stays high and only the payload
    // moves, so each signal sees a single assignment per time step.
    task automatic send_request(input t_op_code op, input logic [DATA_WIDTH-1:0] a,
                                input logic [DATA_WIDTH-1:0] b, input int unsigned gap);
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_if.valid     <= 1'b1;
        req_if.req_type  <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
    endtask

    // Idle gap for the sender. Every fourth block of fifty items runs back to back so that
    // stretches without idling appear as well.
    function automatic int unsigned sender_gap();
        if ((item_index / 50) % 4 == 1)
            return 0;
        return $urandom_range(0, 11);
    endfunction

    // Operands are biased towards the values where wrapping and sign handling matter, with
    // a good share of fully random words so that every bit is exercised in both states.
    function automatic logic [DATA_WIDTH-1:0] pick_operand();
        logic [DATA_WIDTH-1:0] small_mag;
        small_mag = DATA_WIDTH'($urandom_range(0, 40));
        case ($urandom_range(0, 11))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return MINUS_1;
            3:       return '0;
            4, 5:    return small_mag - DATA_WIDTH'(20);
            6:       return MOST_NEG + small_mag;
            7:       return MOST_POS - small_mag;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic send_directed(input t_op_code op, input logic [DATA_WIDTH-1:0] a,
                                 input logic [DATA_WIDTH-1:0] b);
        send_request(op, a, b, $urandom_range(0, 11));
        item_index++;
    endtask

    // Receiver: before each response it holds ready low for a random number of cycles,
    // except during its own bursts. Once, early on, it holds off for a long stretch while
    // the sender keeps offering, so that the output register and the engine both fill and
    // the request channel must stall.
    initial begin
        int unsigned gap;
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (results_seen == HOLD_OFF_AT)
                gap = HOLD_OFF_CYCLES;
            else if ((results_seen / 40) % 4 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 11);
            repeat (gap) begin
                @(negedge i_clk);
                rsp_if.ready <= 1'b0;
            end
            @(negedge i_clk);
            rsp_if.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!rsp_if.valid);
        end
    end

    initial begin
        t_op_code              op;
        logic [DATA_WIDTH-1:0] a;
        logic [DATA_WIDTH-1:0] b;
        int unsigned           drained;

        // Every input of the block is known from time zero.
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.req_type  = OP_ADD;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        item_index       = 0;
        results_seen     = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: wrapping at both ends for add and subtract, the sign combinations
        // and overflow of the multiply, truncation towards zero, a divisor larger than the
        // dividend, a zero divisor and the most negative value over minus one.
        send_directed(OP_ADD, MOST_POS, 1);
        send_directed(OP_ADD, MOST_NEG, MINUS_1);
        send_directed(OP_ADD, MINUS_1, MINUS_1);
        send_directed(OP_SUB, MOST_NEG, 1);
        send_directed(OP_SUB, MOST_POS, MINUS_1);
        send_directed(OP_SUB, '0, MOST_NEG);
        send_directed(OP_MUL, MOST_POS, MOST_POS);
        send_directed(OP_MUL, MOST_NEG, MINUS_1);
        send_directed(OP_MUL, MOST_NEG, MOST_NEG);
        send_directed(OP_MUL, -32'sd12345, -32'sd678);
        send_directed(OP_MUL, 32'sd77, -32'sd3);
        send_directed(OP_MUL, MOST_POS, '0);
        send_directed(OP_DIV, 32'sd1000, '0);
        send_directed(OP_DIV, '0, '0);
        send_directed(OP_DIV, MOST_NEG, '0);
        send_directed(OP_DIV, MOST_NEG, MINUS_1);
        send_directed(OP_DIV, MOST_NEG, 1);
        send_directed(OP_DIV, -32'sd7, 32'sd2);
        send_directed(OP_DIV, 32'sd7, -32'sd2);
        send_directed(OP_DIV, -32'sd7, -32'sd2);
        send_directed(OP_DIV, 32'sd5, 32'sd7);
        send_directed(OP_DIV, MOST_POS, MOST_NEG);
        send_directed(OP_DIV, MOST_NEG, MOST_POS);
        send_directed(OP_DIV, MOST_NEG, MOST_NEG);
        send_directed(OP_DIV, MINUS_1, MOST_NEG);

        // Random part. Each divide has a one-in-ten chance of a zero divisor on top of the
        // zeros that the operand picker already produces.
        repeat (RANDOM_ITEMS) begin
            op = t_op_code'($urandom_range(0, 3));
            a  = pick_operand();
            b  = pick_operand();
            if (op == OP_DIV && $urandom_range(0, 9) == 0)
                b = '0;
            send_request(op, a, b, sender_gap());
            item_index++;
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        // Drain: wait for every outstanding response, then a little longer so that a
        // spurious extra response would still be caught. The watchdog bounds the wait.
        while (alu_sb.pending_outcomes.size() != 0)
            @(posedge i_clk);
        drained = 0;
        while (drained < DRAIN_CYCLES) begin
            @(posedge i_clk);
            drained++;
        end

        if (alu_sb.fail_count == 0 && alu_sb.pending_outcomes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
